/* sv/efl_pkg.sv */
// ----------------------------------------------------------------------------
// efl_pkg: shared definitions for the field line tracer
// Operation, status and register codes, control structs and small helpers.
// ----------------------------------------------------------------------------
package efl_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [2:0] ST_VERTEX = 3'd0;
  localparam logic [2:0] ST_BOUNDS = 3'd1;
  localparam logic [2:0] ST_LIMIT  = 3'd2;
  localparam logic [2:0] ST_WEAK   = 3'd3;
  localparam logic [2:0] ST_IDLE   = 3'd4;

  localparam logic [2:0] REG_CHARGE_COUNT = 3'd0;
  localparam logic [2:0] REG_STEP_SIZE    = 3'd1;
  localparam logic [2:0] REG_MAX_STEPS    = 3'd2;
  localparam logic [2:0] REG_BOUND_MAX    = 3'd3;
  localparam logic [2:0] REG_MIN_DISTANCE = 3'd4;
  localparam logic [2:0] REG_WEAK_THRESH  = 3'd5;

  typedef struct packed {
    logic start;
    logic mode_sqrt;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] q;
  } charge_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

/* sv/electric_field_line_tracer.sv */
// ----------------------------------------------------------------------------
// electric_field_line_tracer: Euler tracing of field lines over point charges
// Computes the field of a charge table in Q16.16 and steps a trace position.
// ----------------------------------------------------------------------------
// Use: items enter on in_valid/in_stall. A load item writes one charge slot,
// a start item sets the trace position; neither gives a result. An advance
// item gives exactly one result on out_valid/out_stall: a vertex with its
// status, a weak field end, or an idle report when no trace runs.
// An advance item works each charge in use with one root, one scale division
// and three direction divisions of the shared divider (a charge too close
// takes only its root), and then the step with one root and three step
// divisions (a weak field ends before the step divisions; an idle report
// needs none of them).
// One item is worked at a time; in_stall stays high until it is finished.
// The result sits in an output register; while the receiver stalls, load
// and start items are still taken, but a further advance waits for it.
// Registers are written on cfg_valid (cfg_ready is always high); the user
// must write them only while idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) restores the register defaults and ends
// any trace; the charge table keeps its contents and must be loaded first.
// ----------------------------------------------------------------------------
module electric_field_line_tracer #(
  parameter int MAX_CHARGES = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [3:0]         in_charge_slot,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_charge_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z,
  output logic [2:0]         out_status,
  output logic               out_trace_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = (CW > 32 ? CW : 32) + 1;
  localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int NW = $clog2(MAX_CHARGES + 1);
  localparam logic signed [RW-1:0] S32HI = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] S32LO = -S32HI - RW'(1);
  localparam logic signed [RW-1:0] CHI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] CLO = -CHI - RW'(1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_R    = 5'd2;
  localparam logic [4:0] S_D2M  = 5'd3;
  localparam logic [4:0] S_D2A  = 5'd4;
  localparam logic [4:0] S_SQW  = 5'd5;
  localparam logic [4:0] S_DSW  = 5'd6;
  localparam logic [4:0] S_DUW  = 5'd7;
  localparam logic [4:0] S_CM   = 5'd8;
  localparam logic [4:0] S_CA   = 5'd9;
  localparam logic [4:0] S_M2M  = 5'd10;
  localparam logic [4:0] S_M2A  = 5'd11;
  localparam logic [4:0] S_MSW  = 5'd12;
  localparam logic [4:0] S_DM   = 5'd13;
  localparam logic [4:0] S_DDS  = 5'd14;
  localparam logic [4:0] S_DDW  = 5'd15;
  localparam logic [4:0] S_UPD  = 5'd16;
  localparam logic [4:0] S_EMIT = 5'd17;

  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
    if (v > S32HI) return 32'sh7fffffff;
    if (v < S32LO) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [CW-1:0] satc(input logic signed [RW-1:0] v);
    if (v > CHI) return CHI[CW-1:0];
    if (v < CLO) return CLO[CW-1:0];
    return v[CW-1:0];
  endfunction

  logic [4:0]  state_r, state_nxt;
  logic        tracing_r, tracing_nxt;
  logic [15:0] steps_r, steps_nxt;
  logic signed [CW-1:0] cur_r [3];
  logic signed [CW-1:0] cur_nxt [3];

  logic [4:0]  ccount_r;
  logic [20:0] step_r;
  logic [15:0] maxs_r;
  logic [30:0] bound_r;
  logic [20:0] mind_r;
  logic [20:0] thr_r;

  logic [NW-1:0] idx_r, idx_nxt;
  logic [1:0]    k_r, k_nxt;
  logic signed [31:0] rv_r [3];
  logic signed [31:0] rv_nxt [3];
  logic signed [31:0] q_r, q_nxt;
  logic [63:0] d2_r, d2_nxt;
  logic [31:0] d_r, d_nxt;
  logic [30:0] s_r, s_nxt;
  logic [31:0] u_r, u_nxt;
  logic signed [31:0] e_r [3];
  logic signed [31:0] e_nxt [3];
  logic [63:0] m2_r, m2_nxt;
  logic [31:0] em_r, em_nxt;
  logic [20:0] dm_r [3];
  logic [20:0] dm_nxt [3];
  logic [63:0] prod_r;

  logic        ustart_r, ustart_nxt;
  logic        umode_r, umode_nxt;
  logic [63:0] unum_r, unum_nxt;
  logic [63:0] uden_r, uden_nxt;

  logic signed [31:0] res_v_r [3];
  logic signed [31:0] res_v_nxt [3];
  logic [2:0]  res_st_r, res_st_nxt;
  logic        res_dn_r, res_dn_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic signed [31:0] ov_r [3];
  logic signed [31:0] ov_nxt [3];
  logic [2:0]  ost_r, ost_nxt;
  logic        odn_r, odn_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        mem_we;
  efl_pkg::charge_t mem_wdata, mem_rdata;
  efl_pkg::unit_ctl_t uctl;
  efl_pkg::unit_sts_t usts;
  logic [63:0] ures;
  logic [NW-1:0] n_eff;
  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign n_eff = (32'(ccount_r) > MAX_CHARGES) ? NW'(MAX_CHARGES) : NW'(ccount_r);

  assign mem_we    = accept && in_op == efl_pkg::OP_LOAD && 32'(in_charge_slot) < MAX_CHARGES;
  assign mem_wdata = '{x: in_pos_x, y: in_pos_y, z: in_pos_z, q: in_charge_value};

  efl_cmem #(.DEPTH(MAX_CHARGES), .AW(AW)) u_cmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_charge_slot)),
    .wdata (mem_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign uctl.start     = ustart_r;
  assign uctl.mode_sqrt = umode_r;

  efl_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (uctl),
    .num    (unum_r),
    .den    (uden_r),
    .sts    (usts),
    .result (ures)
  );

  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic signed [31:0] cq [3];
    logic [32:0]        cmag;
    logic signed [33:0] sum;
    logic signed [RW-1:0] nv [3];
    logic               last_charge;
    logic               oob;

    cq[0] = mem_rdata.x;
    cq[1] = mem_rdata.y;
    cq[2] = mem_rdata.z;
    cmag  = prod_r[48:16];
    sum   = '0;
    last_charge = ({1'b0, idx_r} + (NW+1)'(1)) == {1'b0, n_eff};
    oob   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      nv[i] = RW'(cur_r[i]);
    end

    state_nxt   = state_r;
    tracing_nxt = tracing_r;
    steps_nxt   = steps_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    q_nxt       = q_r;
    d2_nxt      = d2_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    u_nxt       = u_r;
    m2_nxt      = m2_r;
    em_nxt      = em_r;
    ustart_nxt  = 1'b0;
    umode_nxt   = umode_r;
    unum_nxt    = unum_r;
    uden_nxt    = uden_r;
    res_st_nxt  = res_st_r;
    res_dn_nxt  = res_dn_r;
    mul_a       = '0;
    mul_b       = '0;
    for (int i = 0; i < 3; i++) begin
      cur_nxt[i]   = cur_r[i];
      rv_nxt[i]    = rv_r[i];
      e_nxt[i]     = e_r[i];
      dm_nxt[i]    = dm_r[i];
      res_v_nxt[i] = res_v_r[i];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            efl_pkg::OP_START: begin
              cur_nxt[0]  = satc(RW'(in_pos_x));
              cur_nxt[1]  = satc(RW'(in_pos_y));
              cur_nxt[2]  = satc(RW'(in_pos_z));
              steps_nxt   = '0;
              tracing_nxt = 1'b1;
            end
            efl_pkg::OP_ADVANCE: begin
              if (!tracing_r) begin
                for (int i = 0; i < 3; i++) res_v_nxt[i] = '0;
                res_st_nxt = efl_pkg::ST_IDLE;
                res_dn_nxt = 1'b0;
                state_nxt  = S_EMIT;
              end else begin
                for (int i = 0; i < 3; i++) e_nxt[i] = '0;
                idx_nxt   = '0;
                k_nxt     = '0;
                state_nxt = (n_eff == '0) ? S_M2M : S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_R;
      S_R: begin
        for (int i = 0; i < 3; i++) begin
          rv_nxt[i] = sat32(RW'(cur_r[i]) - RW'(cq[i]));
        end
        q_nxt     = mem_rdata.q;
        d2_nxt    = '0;
        k_nxt     = '0;
        state_nxt = S_D2M;
      end
      S_D2M: begin
        mul_a     = efl_pkg::mag32(rv_r[k_r]);
        mul_b     = efl_pkg::mag32(rv_r[k_r]);
        state_nxt = S_D2A;
      end
      S_D2A: begin
        d2_nxt = d2_r + prod_r;
        if (k_r == 2'd2) begin
          ustart_nxt = 1'b1;
          umode_nxt  = 1'b1;
          unum_nxt   = d2_nxt;
          state_nxt  = S_SQW;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_D2M;
        end
      end
      S_SQW: begin
        if (usts.done) begin
          d_nxt = ures[31:0];
          // Charges within the minimum distance of the trace point are left out of the sum.
          if (ures[31:0] <= 32'(mind_r) || d2_r == '0) begin
            if (last_charge) begin
              k_nxt     = '0;
              state_nxt = S_M2M;
            end else begin
              idx_nxt   = idx_r + NW'(1);
              state_nxt = S_RD;
            end
          end else begin
            ustart_nxt = 1'b1;
            umode_nxt  = 1'b0;
            unum_nxt   = {efl_pkg::mag32(q_r), 32'd0};
            uden_nxt   = d2_r;
            state_nxt  = S_DSW;
          end
        end
      end
      S_DSW: begin
        if (usts.done) begin
          s_nxt      = (ures > 64'd2147483647) ? 31'h7fffffff : ures[30:0];
          k_nxt      = '0;
          ustart_nxt = 1'b1;
          unum_nxt   = {16'd0, efl_pkg::mag32(rv_r[0]), 16'd0};
          uden_nxt   = {32'd0, d_r};
          state_nxt  = S_DUW;
        end
      end
      S_DUW: begin
        if (usts.done) begin
          u_nxt     = ures[31:0];
          state_nxt = S_CM;
        end
      end
      S_CM: begin
        mul_a     = {1'b0, s_r};
        mul_b     = u_r;
        state_nxt = S_CA;
      end
      S_CA: begin
        if (q_r[31] != rv_r[k_r][31]) begin
          sum = 34'(e_r[k_r]) - $signed({1'b0, cmag});
        end else begin
          sum = 34'(e_r[k_r]) + $signed({1'b0, cmag});
        end
        if (sum > 34'sd2147483647) begin
          e_nxt[k_r] = 32'sh7fffffff;
        end else if (sum < -34'sd2147483648) begin
          e_nxt[k_r] = 32'sh80000000;
        end else begin
          e_nxt[k_r] = sum[31:0];
        end
        if (k_r == 2'd2) begin
          if (last_charge) begin
            k_nxt     = '0;
            state_nxt = S_M2M;
          end else begin
            idx_nxt   = idx_r + NW'(1);
            state_nxt = S_RD;
          end
        end else begin
          k_nxt      = k_r + 2'd1;
          ustart_nxt = 1'b1;
          unum_nxt   = {16'd0, efl_pkg::mag32(rv_r[k_r + 2'd1]), 16'd0};
          uden_nxt   = {32'd0, d_r};
          state_nxt  = S_DUW;
        end
      end
      S_M2M: begin
        if (k_r == 2'd0) m2_nxt = '0;
        mul_a     = efl_pkg::mag32(e_r[k_r]);
        mul_b     = efl_pkg::mag32(e_r[k_r]);
        state_nxt = S_M2A;
      end
      S_M2A: begin
        m2_nxt = m2_r + prod_r;
        if (k_r == 2'd2) begin
          ustart_nxt = 1'b1;
          umode_nxt  = 1'b1;
          unum_nxt   = m2_nxt;
          state_nxt  = S_MSW;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_M2M;
        end
      end
      S_MSW: begin
        if (usts.done) begin
          em_nxt = ures[31:0];
          if (ures[31:0] == '0 || ures[31:0] < 32'(thr_r)) begin
            tracing_nxt = 1'b0;
            for (int i = 0; i < 3; i++) res_v_nxt[i] = '0;
            res_st_nxt = efl_pkg::ST_WEAK;
            res_dn_nxt = 1'b1;
            state_nxt  = S_EMIT;
          end else begin
            for (int i = 0; i < 3; i++) res_v_nxt[i] = sat32(RW'(cur_r[i]));
            k_nxt     = '0;
            state_nxt = S_DM;
          end
        end
      end
      S_DM: begin
        mul_a     = 32'(step_r);
        mul_b     = efl_pkg::mag32(e_r[k_r]);
        state_nxt = S_DDS;
      end
      S_DDS: begin
        ustart_nxt = 1'b1;
        umode_nxt  = 1'b0;
        unum_nxt   = prod_r;
        uden_nxt   = {32'd0, em_r};
        state_nxt  = S_DDW;
      end
      S_DDW: begin
        if (usts.done) begin
          // The quotient never exceeds step_size since each |E_k| <= |E|.
          dm_nxt[k_r] = ures[20:0];
          if (k_r == 2'd2) begin
            state_nxt = S_UPD;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_DM;
          end
        end
      end
      S_UPD: begin
        for (int i = 0; i < 3; i++) begin
          if (e_r[i][31]) begin
            nv[i] = RW'(cur_r[i]) - $signed(RW'(dm_r[i]));
          end else begin
            nv[i] = RW'(cur_r[i]) + $signed(RW'(dm_r[i]));
          end
          cur_nxt[i] = satc(nv[i]);
        end
        steps_nxt = (steps_r == 16'hffff) ? steps_r : steps_r + 16'd1;
        oob = RW'(cur_nxt[0]) < $signed(RW'(0)) ||
              RW'(cur_nxt[0]) > $signed(RW'(bound_r)) ||
              RW'(cur_nxt[2]) < $signed(RW'(0)) ||
              RW'(cur_nxt[2]) > $signed(RW'(bound_r));
        if (oob) begin
          tracing_nxt = 1'b0;
          res_st_nxt  = efl_pkg::ST_BOUNDS;
          res_dn_nxt  = 1'b1;
        end else if (steps_nxt >= maxs_r) begin
          tracing_nxt = 1'b0;
          res_st_nxt  = efl_pkg::ST_LIMIT;
          res_dn_nxt  = 1'b1;
        end else begin
          res_st_nxt  = efl_pkg::ST_VERTEX;
          res_dn_nxt  = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loaded from the prepared result once the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    ost_nxt = ost_r;
    odn_nxt = odn_r;
    for (int i = 0; i < 3; i++) ov_nxt[i] = ov_r[i];
    if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      ost_nxt = res_st_r;
      odn_nxt = res_dn_r;
      for (int i = 0; i < 3; i++) ov_nxt[i] = res_v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tracing_r   <= 1'b0;
      steps_r     <= '0;
      ustart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ccount_r    <= 5'd2;
      step_r      <= 21'd3277;
      maxs_r      <= 16'd500;
      bound_r     <= 31'd3276800;
      mind_r      <= 21'd6554;
      thr_r       <= 21'd66;
      for (int i = 0; i < 3; i++) cur_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      tracing_r   <= tracing_nxt;
      steps_r     <= steps_nxt;
      ustart_r    <= ustart_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 3; i++) cur_r[i] <= cur_nxt[i];
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          efl_pkg::REG_CHARGE_COUNT: ccount_r <= cfg_data[4:0];
          efl_pkg::REG_STEP_SIZE:    step_r   <= cfg_data[20:0];
          efl_pkg::REG_MAX_STEPS:    maxs_r   <= cfg_data[15:0];
          efl_pkg::REG_BOUND_MAX:    bound_r  <= cfg_data;
          efl_pkg::REG_MIN_DISTANCE: mind_r   <= cfg_data[20:0];
          efl_pkg::REG_WEAK_THRESH:  thr_r    <= cfg_data[20:0];
          default: ;
        endcase
      end
    end
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    q_r      <= q_nxt;
    d2_r     <= d2_nxt;
    d_r      <= d_nxt;
    s_r      <= s_nxt;
    u_r      <= u_nxt;
    m2_r     <= m2_nxt;
    em_r     <= em_nxt;
    prod_r   <= mul_p;
    umode_r  <= umode_nxt;
    unum_r   <= unum_nxt;
    uden_r   <= uden_nxt;
    res_st_r <= res_st_nxt;
    res_dn_r <= res_dn_nxt;
    ost_r    <= ost_nxt;
    odn_r    <= odn_nxt;
    for (int i = 0; i < 3; i++) begin
      rv_r[i]    <= rv_nxt[i];
      e_r[i]     <= e_nxt[i];
      dm_r[i]    <= dm_nxt[i];
      res_v_r[i] <= res_v_nxt[i];
      ov_r[i]    <= ov_nxt[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_x   = ov_r[0];
  assign out_vertex_y   = ov_r[1];
  assign out_vertex_z   = ov_r[2];
  assign out_status     = ost_r;
  assign out_trace_done = odn_r;

  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ustart_r |-> !usts.busy)
    else $error("divider started while still busy");

  a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == efl_pkg::ST_IDLE |-> !out_trace_done)
    else $error("idle report marked as trace end");

  a_start_traces: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == efl_pkg::OP_START |=> tracing_r && steps_r == '0)
    else $error("start item did not open a trace");

  a_charge_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_R |-> idx_r < n_eff)
    else $error("charge index beyond the charges in use");

  a_weak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == efl_pkg::ST_WEAK |->
      out_trace_done && out_vertex_x == '0 && out_vertex_z == '0)
    else $error("weak field result carries a vertex");

endmodule

/* sv/efl_unit.sv */
// ----------------------------------------------------------------------------
// efl_unit: shared iterative divider and square root
// Restoring division, one quotient bit per cycle for a 64-bit quotient, or a floor
// square root of a 64-bit word, one root bit per cycle for a 32-bit root.
// ----------------------------------------------------------------------------
module efl_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efl_pkg::unit_ctl_t   ctl,
  input  logic [63:0]          num,
  input  logic [63:0]          den,
  output efl_pkg::unit_sts_t   sts,
  output logic [63:0]          result
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        mode_r, mode_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [63:0] den_r, den_nxt;

  logic [64:0] dt;
  logic        dge;
  logic [65:0] qt;
  logic [65:0] trial;
  logic        qge;

  always_comb begin
    dt    = {rem_r, sh_r[63]};
    dge   = dt >= {1'b0, den_r};
    qt    = {rem_r, sh_r[63:62]};
    trial = {acc_r, 2'b01};
    qge   = qt >= trial;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;

    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      mode_nxt = ctl.mode_sqrt;
      cnt_nxt  = ctl.mode_sqrt ? 6'd31 : 6'd63;
      rem_nxt  = '0;
      acc_nxt  = '0;
      sh_nxt   = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (mode_r) begin
        rem_nxt = qge ? 64'(qt - trial) : qt[63:0];
        acc_nxt = {acc_r[62:0], qge};
        sh_nxt  = {sh_r[61:0], 2'b00};
      end else begin
        rem_nxt = dge ? 64'(dt - {1'b0, den_r}) : dt[63:0];
        acc_nxt = {acc_r[62:0], dge};
        sh_nxt  = {sh_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    den_r  <= den_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

/* sv/efl_cmem.sv */
// ----------------------------------------------------------------------------
// efl_cmem: charge table
// One write port and one registered read port; each entry holds x, y, z, q.
// ----------------------------------------------------------------------------
module efl_cmem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  efl_pkg::charge_t  wdata,
  input  logic [AW-1:0]     raddr,
  output efl_pkg::charge_t  rdata
);

  efl_pkg::charge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
